// File: rtl/dual_channel_moving_average_decimator_top_defines.svh
// assertion macros used by the moving average decimator top level
`ifndef DUAL_CHANNEL_MOVING_AVERAGE_DECIMATOR_TOP_DEFINES_SVH
`define DUAL_CHANNEL_MOVING_AVERAGE_DECIMATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DCMAD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcmad assertion failed");

// next-cycle implication, disabled during reset
`define DCMAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcmad assertion failed");

`endif

// File: rtl/dcmad_pkg.sv
// shared types and constants of the moving average decimator
package dcmad_pkg;

  localparam int SAMPLE_W = 10;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // channel tags
  localparam logic CH_POSITION = 1'b0;
  localparam logic CH_CURRENT  = 1'b1;

  // one sample pushed into a channel filter
  typedef struct packed {
    logic    push;
    sample_t sample;
  } dcmad_push_t;

endpackage

// File: rtl/dcmad_if.sv
// valid/ready channel interfaces for samples and averages
interface dcmad_in_if import dcmad_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    channel;
  sample_t sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface dcmad_out_if import dcmad_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t position_average;
  sample_t current_average;

  modport source (output valid, output position_average, output current_average,
                  input ready);
  modport sink (input valid, input position_average, input current_average,
                output ready);
endinterface

// File: rtl/dcmad_ram.sv
// generic single write port ram with registered read
module dcmad_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 10
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dcmad_channel.sv
// one boxcar filter channel: sample ring, running sum and mean
module dcmad_channel import dcmad_pkg::*; #(
  parameter int WINDOW = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  dcmad_push_t push,
  output sample_t     mean
);

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // ceil(2^SHIFT / WINDOW), exact floor division for any sum below 2^SUM_W
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [SLOT_W-1:0] rd_addr;
  logic              wrapped;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  sample_t           rd_data;
  logic              bypass;
  sample_t           bypass_data;
  sample_t           oldest;
  logic [PROD_W-1:0] product;

  // read ahead so the oldest entry is ready when the next sample arrives
  assign slot_next = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  assign rd_addr   = push.push ? slot_next : slot;

  dcmad_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (push.push),
    .waddr (slot),
    .wdata (push.sample),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // entries not yet written since reset count as zero
  assign oldest   = !wrapped ? '0 : (bypass ? bypass_data : rd_data);
  assign sum_next = sum - SUM_W'(oldest) + SUM_W'(push.sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      wrapped <= 1'b0;
      sum     <= '0;
      bypass  <= 1'b0;
    end else begin
      // a one-entry ring reads the slot it is writing
      bypass <= push.push && (rd_addr == slot);
      if (push.push) begin
        slot <= slot_next;
        sum  <= sum_next;
        if (slot == LAST_SLOT) begin
          wrapped <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    bypass_data <= push.sample;
  end

  // division by the window as a reciprocal multiply
  assign product = PROD_W'(sum) * PROD_W'(RECIP);
  assign mean    = product[SHIFT +: SAMPLE_W];

endmodule

// File: rtl/dual_channel_moving_average_decimator_top.sv
// top level of the dual channel moving average decimator
// usage:
//   samples  : valid/ready input, one 10-bit converter sample per transfer,
//              tagged with channel 0 (position) or 1 (current)
//   averages : valid/ready output, both channel averages per transfer
//   cfg_we / cfg_wdata : writes acquisition_enable, change only while idle
// each channel keeps a ring of the last WINDOW samples in a small ram and a
// running sum; the average is the sum divided by WINDOW, truncated.
// with acquisition enabled every current sample completes one pair and every
// DECIMATION-th pair produces one output transfer.
// throughput: one sample per cycle while intake is not stalled.
// the sample transfer that completes the decimation count updates the sum
// registers and sets a pending flag; the output register then loads the averages.
// a waiting output does not stop sample intake; samples stall only while a
// second result is due and the output register is still held by the receiver.
// reset clears sums, ring fill state, the pair count, the enable and the
// output valid; ring ram contents need no clearing.
module dual_channel_moving_average_decimator_top import dcmad_pkg::*; #(
  parameter int WINDOW     = 10,
  parameter int DECIMATION = 10
) (
  input  logic               clk,
  input  logic               rst,
  dcmad_in_if.sink           samples,
  dcmad_out_if.source        averages,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

`include "dual_channel_moving_average_decimator_top_defines.svh"

  localparam int CNT_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam logic [CNT_W-1:0] LAST_PAIR = CNT_W'(DECIMATION - 1);

  logic        acq_enable;
  logic [CNT_W-1:0] pair_count;
  logic        emit_pend;
  logic        out_free;
  logic        accept;
  logic        pair_done;
  logic        emit;
  dcmad_push_t pos_push;
  dcmad_push_t cur_push;
  sample_t     pos_mean;
  sample_t     cur_mean;

  // output register can take a result this cycle
  assign out_free = !averages.valid || averages.ready;
  // stall intake only when a result is pending and cannot move out
  assign samples.ready = !emit_pend || out_free;
  assign accept = samples.valid && samples.ready;

  assign pos_push.push   = accept && (samples.channel == CH_POSITION);
  assign pos_push.sample = samples.sample;
  assign cur_push.push   = accept && (samples.channel == CH_CURRENT);
  assign cur_push.sample = samples.sample;

  // a current sample completes a pair; counted only while enabled
  assign pair_done = cur_push.push && acq_enable;
  assign emit      = pair_done && (pair_count == LAST_PAIR);

  dcmad_channel #(.WINDOW (WINDOW)) u_position (
    .clk  (clk),
    .rst  (rst),
    .push (pos_push),
    .mean (pos_mean)
  );

  dcmad_channel #(.WINDOW (WINDOW)) u_current (
    .clk  (clk),
    .rst  (rst),
    .push (cur_push),
    .mean (cur_mean)
  );

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      acq_enable <= 1'b0;
    end else if (cfg_we) begin
      acq_enable <= cfg_wdata;
    end
  end

  // decimation count and pending result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
      emit_pend  <= 1'b0;
    end else begin
      if (pair_done) begin
        pair_count <= emit ? '0 : pair_count + 1'b1;
      end
      if (emit) begin
        emit_pend <= 1'b1;
      end else if (out_free) begin
        emit_pend <= 1'b0;
      end
    end
  end

  // output register, loaded from the sums left by the emitting sample
  always_ff @(posedge clk) begin
    if (rst) begin
      averages.valid <= 1'b0;
    end else if (emit_pend && out_free) begin
      averages.valid <= 1'b1;
    end else if (averages.ready) begin
      averages.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_pend && out_free) begin
      averages.position_average <= pos_mean;
      averages.current_average  <= cur_mean;
    end
  end

  `DCMAD_ASSERT_IMPL(a_stall_when_blocked, clk, rst, emit_pend && !out_free, !samples.ready)
  `DCMAD_ASSERT_NEXT(a_pending_moves_out, clk, rst, emit_pend && out_free, averages.valid)
  `DCMAD_ASSERT_IMPL(a_pair_range, clk, rst, 1'b1, pair_count <= LAST_PAIR)
  `DCMAD_ASSERT_NEXT(a_position_keeps_count, clk, rst, pos_push.push, $stable(pair_count))
  `DCMAD_ASSERT_NEXT(a_disabled_keeps_count, clk, rst, !acq_enable && !cfg_we, $stable(pair_count))

endmodule

// File: tb/sv/dual_channel_moving_average_decimator_top_test.sv
// self-checking testbench of the dual channel moving average decimator
module dual_channel_moving_average_decimator_top_test;
  import dcmad_pkg::*;

  localparam int WINDOW      = 10;
  localparam int DECIMATION  = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE      = 4;   // idle clocks added at the end of each drain

  // both averages of one output transfer
  typedef struct packed {
    sample_t pos;
    sample_t cur;
  } avg_pair_t;

  // running copy of both boxcar filters and the decimation count
  class average_checker;
    sample_t   ring [2][WINDOW];
    logic [13:0] sum [2];
    logic [3:0]  slot [2];
    sample_t   mean [2];
    logic [3:0]  pair_count;
    logic        acq_on;
    avg_pair_t   due_averages [$];
    int          errors;

    function new();
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < WINDOW; i++) ring[c][i] = '0;
        sum[c]  = '0;
        slot[c] = '0;
        mean[c] = '0;
      end
      pair_count = '0;
      acq_on     = 1'b0;
      errors     = 0;
    endfunction

    function void set_enable(logic value);
      acq_on = value;
    endfunction

    function int pending();
      return due_averages.size();
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // one accepted sample transfer: update its filter, maybe owe an output
    function void note_sample(logic channel, sample_t value);
      int c;
      c = (channel == CH_CURRENT) ? 1 : 0;
      sum[c] = sum[c] - ring[c][slot[c]] + value;
      ring[c][slot[c]] = value;
      slot[c] = (slot[c] == WINDOW - 1) ? 4'd0 : slot[c] + 4'd1;
      mean[c] = sample_t'(sum[c] / WINDOW);
      if (channel == CH_CURRENT && acq_on) begin
        pair_count++;
        if (pair_count >= DECIMATION) begin
          pair_count = '0;
          due_averages.push_back('{pos: mean[0], cur: mean[1]});
        end
      end
    endfunction

    task check_averages(sample_t pos, sample_t cur);
      avg_pair_t want;
      if (due_averages.size() == 0) begin
        report($sformatf("unexpected averages pos=%0d cur=%0d", pos, cur));
      end else begin
        want = due_averages.pop_front();
        if (pos !== want.pos)
          report($sformatf("position average %0d, want %0d", pos, want.pos));
        if (cur !== want.cur)
          report($sformatf("current average %0d, want %0d", cur, want.cur));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  dcmad_in_if  samples_if ();
  dcmad_out_if averages_if ();

  dual_channel_moving_average_decimator_top #(
    .WINDOW     (WINDOW),
    .DECIMATION (DECIMATION)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .averages  (averages_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  average_checker chk;

  // random idling on both sides, switched off for one long stretch
  logic idle_on;
  // each bump of hold_asks starts a receiver hold-off counted down from HOLD_CYCLES
  int   hold_asks;
  int   hold_seen;
  int   hold_left;

  // 10 time unit clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: checks each output transfer, then picks ready for the next edge
  always @(posedge clk) begin
    if (!rst && averages_if.valid && averages_if.ready)
      chk.check_averages(averages_if.position_average, averages_if.current_average);
    if (hold_seen != hold_asks) begin
      // long hold-off so the output register stays full and intake stalls
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
      averages_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      averages_if.ready <= 1'b0;
    end else if (idle_on) begin
      averages_if.ready <= ($urandom_range(0, 99) >= 20);
    end else begin
      averages_if.ready <= 1'b1;
    end
  end

  // mostly random, with the extremes showing up often
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(0);
      1:       return sample_t'(1023);
      default: return sample_t'($urandom_range(0, 1023));
    endcase
  endfunction

  // offer one sample and wait for its transfer, with random gaps before it
  task automatic send_sample(input logic channel, input sample_t value);
    while (idle_on && $urandom_range(0, 99) < 20) begin
      samples_if.valid <= 1'b0;
      @(posedge clk);
    end
    samples_if.valid   <= 1'b1;
    samples_if.channel <= channel;
    samples_if.sample  <= value;
    do @(posedge clk); while (!samples_if.ready);
    chk.note_sample(channel, value);
  endtask

  // stop offering and wait for every owed output, then let the pipe settle
  task automatic drain();
    int n;
    n = 0;
    samples_if.valid <= 1'b0;
    while (chk.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // acquisition enable is only changed with the block idle
  task automatic write_enable(input logic value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    chk.set_enable(value);
  endtask

  // mostly well-formed position/current pairs, some lone samples as noise
  task automatic send_mix(input int items);
    int n;
    n = 0;
    while (n < items) begin
      if ($urandom_range(0, 99) < 85) begin
        send_sample(CH_POSITION, pick_sample());
        send_sample(CH_CURRENT, pick_sample());
        n += 2;
      end else begin
        send_sample(logic'($urandom_range(0, 1)), pick_sample());
        n += 1;
      end
    end
  endtask

  initial begin
    chk = new();
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = 1'b0;
    samples_if.valid     = 1'b0;
    samples_if.channel   = CH_POSITION;
    samples_if.sample    = '0;
    averages_if.ready    = 1'b0;
    idle_on              = 1'b1;
    hold_asks            = 0;
    hold_seen            = 0;
    hold_left            = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: with acquisition off, filters run but nothing comes out
    write_enable(1'b0);
    send_sample(CH_POSITION, sample_t'(1023));
    send_sample(CH_CURRENT, sample_t'(0));
    send_sample(CH_CURRENT, sample_t'(1023));
    send_sample(CH_POSITION, sample_t'(0));

    // directed: ten full-scale pairs give exactly one output
    write_enable(1'b1);
    for (int i = 0; i < 10; i++) begin
      send_sample(CH_POSITION, sample_t'(1023));
      send_sample(CH_CURRENT, sample_t'(1023));
    end

    // random with idling on both sides
    send_mix(400);

    // count holds while acquisition is off
    write_enable(1'b0);
    send_mix(150);

    // no idling, and a long receiver hold-off to back the block up
    write_enable(1'b1);
    idle_on   <= 1'b0;
    hold_asks <= hold_asks + 1;
    send_mix(400);

    write_enable(1'b0);
    idle_on <= 1'b1;
    send_mix(50);

    write_enable(1'b1);
    send_mix(300);

    drain();
    while (chk.pending() != 0) begin
      chk.report($sformatf("averages never arrived pos=%0d cur=%0d",
                           chk.due_averages[0].pos, chk.due_averages[0].cur));
      void'(chk.due_averages.pop_front());
    end

    if (chk.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dcmad_pkg.sv
rtl/dcmad_if.sv
rtl/dcmad_ram.sv
rtl/dcmad_channel.sv
rtl/dual_channel_moving_average_decimator_top.sv
tb/sv/dual_channel_moving_average_decimator_top_test.sv
